FILE: src/crc32fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32fr_pkg
// shared constants, types and the crc-32 byte update for the frame receiver
// ----------------------------------------------------------------------------
package crc32fr_pkg;

  localparam int MAX_PAYLOAD    = 64;
  localparam int PREAMBLE_BYTES = 4;
  localparam int LEN_W          = 7;   // holds 0 .. MAX_PAYLOAD
  localparam int IDX_W          = 6;   // payload buffer address
  localparam int PRE_SEL_W      = 2;   // preamble byte select
  localparam int APB_ADDR_W     = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // register index decoded from paddr[2]
  localparam logic REG_PREAMBLE = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DEST,
    PH_SRC,
    PH_SIZE,
    PH_DATA,
    PH_CSUM
  } ph_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_HOLD
  } em_state_t;

  // parser to emitter: start of a message run
  typedef struct packed {
    logic             start;
    logic [7:0]       src;
    logic [LEN_W-1:0] len;
  } emit_req_t;

  // emitter to parser: occupancy
  typedef struct packed {
    logic busy;      // reads still to issue
    logic holding;   // a result waits in the output register
  } emit_stat_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: src/crc32fr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32fr_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module crc32fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/crc32fr_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32fr_parse
// frame parser: preamble hunt, header, payload write, crc and checksum check
// ----------------------------------------------------------------------------
module crc32fr_parse (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [31:0]                  preamble_word,
  input  wire crc32fr_pkg::emit_stat_t      emit_stat,
  output crc32fr_pkg::emit_req_t            emit_req,
  output logic                              ram_we,
  output logic [crc32fr_pkg::IDX_W-1:0]     ram_waddr,
  output logic [7:0]                        ram_wdata
);

  localparam int LW = crc32fr_pkg::LEN_W;

  crc32fr_pkg::ph_t phase, phase_next;
  logic [LW-1:0] byte_count, byte_count_next;
  logic [7:0]    src_byte, src_byte_next;
  logic [LW-1:0] size_byte, size_byte_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [23:0]   rx_checksum, rx_checksum_next;

  logic          in_fire;
  logic          csum_final;
  logic [LW-1:0] size_clamped;
  logic [LW-1:0] count_inc;
  logic [LW-1:0] hunt_count;
  logic [7:0]    pre_byte;
  logic [31:0]   crc_upd;
  logic [7:0]    crc_in;

  assign csum_final = (phase == crc32fr_pkg::PH_CSUM) && (byte_count == LW'(3));
  // stall while the emitter reads, and hold back the checksum end while
  // the previous run still sits in the output register
  assign in_ready = !emit_stat.busy && !(csum_final && emit_stat.holding);
  assign in_fire  = in_valid && in_ready;

  assign size_clamped = (rx_byte > 8'(crc32fr_pkg::MAX_PAYLOAD)) ?
                        LW'(crc32fr_pkg::MAX_PAYLOAD) : rx_byte[LW-1:0];
  assign count_inc  = byte_count + LW'(1);
  assign hunt_count = (byte_count >= LW'(crc32fr_pkg::PREAMBLE_BYTES)) ? '0 : byte_count;
  assign pre_byte   = preamble_word[{hunt_count[crc32fr_pkg::PRE_SEL_W-1:0], 3'b000} +: 8];
  assign crc_in     = (phase == crc32fr_pkg::PH_SIZE) ? {1'b0, size_clamped} : rx_byte;
  assign crc_upd    = crc32fr_pkg::crc_feed(running_crc, crc_in);

  assign ram_we    = in_fire && (phase == crc32fr_pkg::PH_DATA);
  assign ram_waddr = byte_count[crc32fr_pkg::IDX_W-1:0];
  assign ram_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= crc32fr_pkg::PH_HUNT;
      byte_count  <= '0;
      src_byte    <= '0;
      size_byte   <= '0;
      running_crc <= crc32fr_pkg::CRC_INIT;
      rx_checksum <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      src_byte    <= src_byte_next;
      size_byte   <= size_byte_next;
      running_crc <= running_crc_next;
      rx_checksum <= rx_checksum_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    src_byte_next    = src_byte;
    size_byte_next   = size_byte;
    running_crc_next = running_crc;
    rx_checksum_next = rx_checksum;
    emit_req.start   = 1'b0;
    emit_req.src     = src_byte;
    emit_req.len     = size_byte;
    if (in_fire) begin
      unique case (phase)
        crc32fr_pkg::PH_DEST: begin
          running_crc_next = crc_upd;
          phase_next       = crc32fr_pkg::PH_SRC;
        end
        crc32fr_pkg::PH_SRC: begin
          src_byte_next    = rx_byte;
          running_crc_next = crc_upd;
          phase_next       = crc32fr_pkg::PH_SIZE;
        end
        crc32fr_pkg::PH_SIZE: begin
          size_byte_next   = size_clamped;
          running_crc_next = crc_upd;
          byte_count_next  = '0;
          rx_checksum_next = '0;
          phase_next       = (size_clamped == '0) ? crc32fr_pkg::PH_CSUM
                                                  : crc32fr_pkg::PH_DATA;
        end
        crc32fr_pkg::PH_DATA: begin
          running_crc_next = crc_upd;
          if (count_inc >= size_byte) begin
            byte_count_next  = '0;
            rx_checksum_next = '0;
            phase_next       = crc32fr_pkg::PH_CSUM;
          end else begin
            byte_count_next = count_inc;
          end
        end
        crc32fr_pkg::PH_CSUM: begin
          unique case (byte_count[1:0])
            2'd0:    rx_checksum_next[7:0]   = rx_byte;
            2'd1:    rx_checksum_next[15:8]  = rx_byte;
            2'd2:    rx_checksum_next[23:16] = rx_byte;
            default: ;
          endcase
          byte_count_next = count_inc;
          if (csum_final) begin
            if ({rx_byte, rx_checksum} == ~running_crc) begin
              emit_req.start = 1'b1;
            end
            phase_next       = crc32fr_pkg::PH_HUNT;
            byte_count_next  = '0;
            running_crc_next = crc32fr_pkg::CRC_INIT;
          end
        end
        default: begin
          // preamble hunt, also for codes outside the list
          phase_next = crc32fr_pkg::PH_HUNT;
          if (rx_byte == pre_byte) begin
            running_crc_next = crc_upd;
            if (hunt_count + LW'(1) >= LW'(crc32fr_pkg::PREAMBLE_BYTES)) begin
              byte_count_next = '0;
              phase_next      = crc32fr_pkg::PH_DEST;
            end else begin
              byte_count_next = hunt_count + LW'(1);
            end
          end else begin
            byte_count_next  = '0;
            running_crc_next = crc32fr_pkg::CRC_INIT;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_data_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == crc32fr_pkg::PH_DATA) |-> (byte_count < size_byte))
    else $error("payload count beyond frame size");
`endif

endmodule
`default_nettype wire

FILE: src/crc32fr_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32fr_emit
// message emitter: reads the payload buffer and drives the output register
// ----------------------------------------------------------------------------
module crc32fr_emit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire crc32fr_pkg::emit_req_t       emit_req,
  output crc32fr_pkg::emit_stat_t           emit_stat,
  output logic [crc32fr_pkg::IDX_W-1:0]     ram_raddr,
  input  wire logic [7:0]                   ram_rdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        source_addr,
  output logic [crc32fr_pkg::LEN_W-1:0]     payload_len,
  output logic [7:0]                        data_byte,
  output logic [crc32fr_pkg::IDX_W-1:0]     byte_index,
  output logic                              last
);

  localparam int LW = crc32fr_pkg::LEN_W;

  crc32fr_pkg::em_state_t state, state_next;
  logic [LW-1:0] k, k_next;
  logic [7:0]    src_q;
  logic [LW-1:0] len_q;
  logic [LW-1:0] run_cnt;
  logic          load;

  assign run_cnt   = (len_q == '0) ? LW'(1) : len_q;
  assign ram_raddr = k[crc32fr_pkg::IDX_W-1:0];
  assign load      = (state == crc32fr_pkg::EM_READ);
  assign out_valid = (state == crc32fr_pkg::EM_HOLD);

  assign emit_stat.busy    = (state == crc32fr_pkg::EM_READ) ||
                             ((state == crc32fr_pkg::EM_HOLD) && !last);
  assign emit_stat.holding = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crc32fr_pkg::EM_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req.start) begin
      src_q <= emit_req.src;
      len_q <= emit_req.len;
    end
    if (load) begin
      source_addr <= src_q;
      payload_len <= len_q;
      data_byte   <= (len_q == '0) ? 8'd0 : ram_rdata;
      byte_index  <= k[crc32fr_pkg::IDX_W-1:0];
      last        <= (k + LW'(1) == run_cnt);
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      crc32fr_pkg::EM_IDLE: begin
        // address zero is already on the read port
        if (emit_req.start) begin
          state_next = crc32fr_pkg::EM_READ;
        end
      end
      crc32fr_pkg::EM_READ: begin
        k_next     = k + LW'(1);
        state_next = crc32fr_pkg::EM_HOLD;
      end
      crc32fr_pkg::EM_HOLD: begin
        if (out_ready) begin
          if (last) begin
            k_next     = '0;
            state_next = crc32fr_pkg::EM_IDLE;
          end else begin
            state_next = crc32fr_pkg::EM_READ;
          end
        end
      end
      default: begin
        k_next     = '0;
        state_next = crc32fr_pkg::EM_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    emit_req.start |-> (state == crc32fr_pkg::EM_IDLE))
    else $error("message run started while emitter busy");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == crc32fr_pkg::EM_READ) |=> (state == crc32fr_pkg::EM_HOLD))
    else $error("read data not loaded into output register");

  a_idle_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (state == crc32fr_pkg::EM_IDLE) |-> (k == '0))
    else $error("read index not rewound after run");
`endif

endmodule
`default_nettype wire

FILE: src/crc32_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_frame_receiver_unit
// preamble / length / crc-32 frame receiver with buffered payload replay
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready / rx_byte): one received byte per
//   request. bytes are taken one per cycle, stalls aside, as it parses a frame:
//   preamble hunt, destination, source, size (clamped to 64), payload into a
//   64-byte buffer ram, then a little-endian crc-32 checksum.
//   output channel (out_valid / out_ready / result fields): on a good
//   checksum the frame comes out as one request per payload byte (one request
//   with data_byte zero for an empty frame), last set on the final one.
//   after the last checksum byte is taken, the first result passes the read
//   state, then the output register; each further result is a buffer read,
//   then the output register, and starts only once the held one is taken.
//   input is stalled while buffer reads of a run remain; the last result may
//   wait in the output register while the next frame streams in, and only
//   the final checksum byte of that frame is held until it is taken.
//   reset (rst, synchronous) returns to the preamble hunt with the crc at all
//   ones and clears the preamble register; the buffer needs no clearing.
//   apb register 0 (addr 0): preamble_word, first byte in bits 7:0
// ----------------------------------------------------------------------------
module crc32_frame_receiver_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // apb configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crc32fr_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,
  // byte input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          rx_byte,
  // message output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [7:0]                          source_addr,
  output logic      [crc32fr_pkg::LEN_W-1:0]       payload_len,
  output logic      [7:0]                          data_byte,
  output logic      [crc32fr_pkg::IDX_W-1:0]       byte_index,
  output logic                                     last
);

  logic [31:0] preamble_word;
  logic        reg_sel;

  crc32fr_pkg::emit_req_t  emit_req;
  crc32fr_pkg::emit_stat_t emit_stat;

  logic                          ram_we;
  logic [crc32fr_pkg::IDX_W-1:0] ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [crc32fr_pkg::IDX_W-1:0] ram_raddr;
  logic [7:0]                    ram_rdata;

  // apb register file: a single register where paddr[2] is zero, others read zero
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == crc32fr_pkg::REG_PREAMBLE);
  assign prdata  = reg_sel ? preamble_word : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_word <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      preamble_word <= pwdata;
    end
  end

  // header parse, crc and payload write
  crc32fr_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .preamble_word (preamble_word),
    .emit_stat     (emit_stat),
    .emit_req      (emit_req),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  // payload buffer, written during the data phase, read during replay
  crc32fr_ram #(
    .WIDTH (8),
    .DEPTH (crc32fr_pkg::MAX_PAYLOAD)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // replay of an accepted frame
  crc32fr_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .emit_req    (emit_req),
    .emit_stat   (emit_stat),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .source_addr (source_addr),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_no_write_during_replay: assert property (@(posedge clk) disable iff (rst)
    emit_stat.busy |-> !ram_we)
    else $error("payload buffer written while replay reads remain");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("new run started on the cycle the previous run ended");
`endif

endmodule
`default_nettype wire
